### rtl/core/fip_pkg.sv
// Package for the Feistel index permutation core.
// Holds widths, register codes, reset values, shared types and the key byte select.
// No dependencies.
package fip_pkg;

    localparam int unsigned CNT_W          = 7;   // holds a round count up to 127
    localparam int unsigned KEY_BYTES      = 16;
    localparam int unsigned DEF_MAX_ROUNDS = 16;
    localparam int unsigned MIX_SHIFT      = 16;
    localparam logic [31:0] MIX_MULT       = 32'h045d_9f3b;
    localparam int unsigned DATA_W         = 64;
    localparam int unsigned ADDR_W         = 5;

    localparam logic [1:0] REG_DOMAIN = 2'd0;
    localparam logic [1:0] REG_KEY_LO = 2'd1;
    localparam logic [1:0] REG_KEY_HI = 2'd2;
    localparam logic [1:0] REG_ROUNDS = 2'd3;

    localparam logic [31:0] RST_DOMAIN = 32'd65536;
    localparam logic [4:0]  RST_ROUNDS = 5'd4;

    typedef struct packed {
        logic [31:0]          domain;
        logic [31:0]          mask;
        logic [4:0]           half;
        logic [CNT_W-1:0]     cnt;
        logic [8*KEY_BYTES-1:0] key;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [31:0] lh;
        logic [31:0] rh;
    } t_item;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] rem;
    } t_div;

    function automatic logic [7:0] key_byte(input logic [8*KEY_BYTES-1:0] key,
                                            input logic [3:0] idx);
        key_byte = key[8*idx +: 8];
    endfunction

endpackage

### rtl/core/fip_round_cell.sv
// One Feistel round: three registered stages (premix and multiply, multiply, swap).
// Depends on fip_pkg.
module fip_round_cell
    import fip_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(IDX);

    logic        r_v1, r_v2, r_v3;
    t_item       r_it1, r_it2, r_it3;
    logic        r_act1, r_act2;
    logic [31:0] r_p1, r_p2;

    logic             w_act;
    logic [CNT_W-1:0] w_round;
    logic [3:0]       w_kidx;
    logic [31:0]      w_d, w_x, w_y, w_f;
    t_item            n_it3;

    always_comb begin
        w_act   = CELL_IDX < i_cfg.cnt;
        w_round = i_item.op ? (i_cfg.cnt - CNT_W'(1) - CELL_IDX) : CELL_IDX;
        w_kidx  = w_round[3:0];
        w_d     = (i_item.op ? i_item.lh : i_item.rh) ^
                  {key_byte(i_cfg.key, w_kidx), key_byte(i_cfg.key, w_kidx + 4'd1), 16'h0};
        w_x     = (w_d >> MIX_SHIFT) ^ w_d;
        w_y     = (r_p1 >> MIX_SHIFT) ^ r_p1;
        w_f     = ((r_p2 >> MIX_SHIFT) ^ r_p2) & i_cfg.mask;
        n_it3   = r_it2;
        if (r_act2) begin
            if (r_it2.op) begin
                n_it3.rh = r_it2.lh;
                n_it3.lh = r_it2.rh ^ w_f;
            end else begin
                n_it3.lh = r_it2.rh;
                n_it3.rh = r_it2.lh ^ w_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1  <= i_item;
            r_act1 <= w_act;
            r_p1   <= w_x * MIX_MULT;
            r_it2  <= r_it1;
            r_act2 <= r_act1;
            r_p2   <= w_y * MIX_MULT;
            r_it3  <= n_it3;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;

endmodule

### rtl/core/fip_mod_cell.sv
// One restoring remainder step: shift in one dividend bit, subtract N if it fits.
// Depends on fip_pkg.
module fip_mod_cell
    import fip_pkg::*;
#(
    parameter int unsigned BIT = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [31:0] i_domain,
    input  logic        i_valid,
    input  t_div        i_div,
    output logic        o_valid,
    output t_div        o_div
);

    logic        r_valid;
    t_div        r_div;
    logic [32:0] w_t, w_diff;
    t_div        n_div;

    always_comb begin
        w_t        = {i_div.rem, i_div.num[BIT]};
        w_diff     = w_t - {1'b0, i_domain};
        n_div.num  = i_div.num;
        n_div.rem  = (w_t >= {1'b0, i_domain}) ? w_diff[31:0] : w_t[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

### rtl/core/feistel_index_permutation_core.sv
// Top level of the Feistel index permutation core: register port, split stage,
// chain of round cells, pack stage, chain of remainder cells and output register.
// Depends on fip_pkg, fip_round_cell and fip_mod_cell.
//
// Usage: an index and a direction (op: 0 forward, 1 inverse) are a transfer on the
// input channel (i_in_valid / o_in_ready); the mapped index leaves on the output
// channel (o_out_valid / i_out_ready), one result per input, in order. The pipeline
// holds one split stage, three stages per round cell (two 32x32 multiplies per
// round), one pack stage, one remainder cell per bit of the 32-bit index, and the
// output register. Throughput is one index per cycle; all cells are present whatever
// round_count holds, unused rounds pass the halves through. The pipeline advances
// while the output register is empty or being taken; when the receiver stalls, every
// stage holds and o_in_ready drops in the same cycle. Reset empties the pipeline and
// loads the register defaults (N = 65536, key zero, four rounds). Registers must be
// written over the APB port only while the core is idle; the core does not enforce
// this. An index may follow in the next cycle: the split stage takes half width and
// mask straight from the registers, later stages use a registered copy.
module feistel_index_permutation_core
    import fip_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = DEF_MAX_ROUNDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [31:0]       i_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_mapped_index
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROUNDS);

    logic [31:0] r_domain;
    logic [63:0] r_key_lo, r_key_hi;
    logic [4:0]  r_rounds;
    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic [31:0] w_nm1;
    logic [5:0]  w_bits;
    logic [CNT_W-1:0] w_rounds_ext;
    logic        w_wr;
    logic        w_en;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain <= RST_DOMAIN;
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_rounds <= RST_ROUNDS;
        end else if (w_wr) begin
            case (paddr[4:3])
                REG_DOMAIN: r_domain <= pwdata[31:0];
                REG_KEY_LO: r_key_lo <= pwdata;
                REG_KEY_HI: r_key_hi <= pwdata;
                REG_ROUNDS: r_rounds <= pwdata[4:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_DOMAIN: prdata = {32'h0, r_domain};
            REG_KEY_LO: prdata = r_key_lo;
            REG_KEY_HI: prdata = r_key_hi;
            REG_ROUNDS: prdata = {59'h0, r_rounds};
            default:    prdata = '0;
        endcase
    end

    // Bit count: zero means 2^32, otherwise one past the top set bit of N-1
    always_comb begin
        w_nm1  = r_domain - 32'd1;
        w_bits = 6'd0;
        for (int j = 0; j < 32; j++) begin
            if (w_nm1[j]) begin
                w_bits = 6'(j + 1);
            end
        end
        if (r_domain == 32'd0) begin
            w_bits = 6'd32;
        end
        w_rounds_ext  = CNT_W'(r_rounds);
        n_cfg.domain  = r_domain;
        n_cfg.half    = w_bits[5:1];
        n_cfg.mask    = (32'd1 << w_bits[5:1]) - 32'd1;
        n_cfg.cnt     = (w_rounds_ext > MAX_CNT) ? MAX_CNT : w_rounds_ext;
        n_cfg.key     = {r_key_hi, r_key_lo};
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // Pipeline advances while the output register is free or being drained
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    logic  r_s_valid;
    t_item r_s_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_en) begin
            r_s_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_item.op <= i_op;
            r_s_item.lh <= i_index >> n_cfg.half;
            r_s_item.rh <= i_index & n_cfg.mask;
        end
    end

    logic  w_rv [0:MAX_ROUNDS];
    t_item w_ri [0:MAX_ROUNDS];

    assign w_rv[0] = r_s_valid;
    assign w_ri[0] = r_s_item;

    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
        fip_round_cell #(
            .IDX (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (r_cfg),
            .i_valid (w_rv[g]),
            .i_item  (w_ri[g]),
            .o_valid (w_rv[g+1]),
            .o_item  (w_ri[g+1])
        );
    end

    logic r_p_valid;
    t_div r_p_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_rv[MAX_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_div.num <= (w_ri[MAX_ROUNDS].lh << r_cfg.half) | w_ri[MAX_ROUNDS].rh;
            r_p_div.rem <= '0;
        end
    end

    logic w_mv [0:32];
    t_div w_md [0:32];

    assign w_mv[0] = r_p_valid;
    assign w_md[0] = r_p_div;

    for (genvar k = 0; k < 32; k++) begin : g_mod
        fip_mod_cell #(
            .BIT (31 - k)
        ) u_mod (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_domain (r_cfg.domain),
            .i_valid  (w_mv[k]),
            .i_div    (w_md[k]),
            .o_valid  (w_mv[k+1]),
            .o_div    (w_md[k+1])
        );
    end

    logic        r_out_valid;
    logic [31:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_mv[32];
        end
    end

    // A zero domain stands for 2^32: skip the reduction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= (r_cfg.domain == 32'd0) ? w_md[32].num : w_md[32].rem;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mapped_index = r_out_data;

endmodule

### rtl/core/fip_checker.sv
// Port-level checks for the Feistel index permutation core, bound to the top level.
// Depends on fip_pkg and feistel_index_permutation_core.
module fip_checker
    import fip_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              pready,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [31:0]       o_mapped_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_mapped_index))
        else $error("output changed while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output drain");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind feistel_index_permutation_core fip_checker u_fip_checker (.*);

### tb/tb_feistel_index_permutation_core.sv
// Testbench for the Feistel index permutation core: APB register setup, random and
// directed index traffic with handshake idling, and an in-order check of mapped indices.
// Depends on fip_pkg and feistel_index_permutation_core.

class perm_scoreboard;
    logic [31:0] domain;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  rounds;
    logic [31:0] pending[$];
    int          mismatches;

    function new();
        domain     = fip_pkg::RST_DOMAIN;
        key_lo     = '0;
        key_hi     = '0;
        rounds     = fip_pkg::RST_ROUNDS;
        mismatches = 0;
    endfunction

    function logic [7:0] key_at(int unsigned k);
        int unsigned j;
        j = k % 16;
        if (j < 8) return key_lo[8*j +: 8];
        return key_hi[8*(j-8) +: 8];
    endfunction

    function logic [31:0] mix(logic [31:0] half_val, int unsigned r);
        logic [31:0] d;
        d = half_val ^ {key_at(r), key_at(r + 1), 16'h0};
        d = ((d >> 16) ^ d) * 32'h045d_9f3b;
        d = ((d >> 16) ^ d) * 32'h045d_9f3b;
        return (d >> 16) ^ d;
    endfunction

    function logic [31:0] permute(logic op, logic [31:0] x);
        int unsigned bits;
        int unsigned hw;
        int unsigned cnt;
        logic [31:0] mask;
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] t;
        logic [31:0] packed_val;
        bits = 0;
        if (domain == 0) bits = 32;
        else while (bits < 32 && (64'd1 << bits) < {32'd0, domain}) bits++;
        hw   = bits / 2;
        mask = (32'd1 << hw) - 32'd1;
        cnt  = (rounds > 16) ? 16 : rounds;
        lh   = x >> hw;
        rh   = x & mask;
        for (int unsigned i = 0; i < cnt; i++) begin
            if (!op) begin
                t  = lh;
                lh = rh;
                rh = t ^ (mix(rh, i) & mask);
            end else begin
                t  = rh;
                rh = lh;
                lh = t ^ (mix(lh, cnt - 1 - i) & mask);
            end
        end
        packed_val = (lh << hw) | rh;
        if (domain != 0) packed_val = packed_val % domain;
        return packed_val;
    endfunction

    function void note_index(logic op, logic [31:0] x);
        pending.push_back(permute(op, x));
    endfunction

    function void check_mapped(logic [31:0] got);
        logic [31:0] want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) $display("mapped_index mismatch: exp %h got %h", want, got);
        end
    endfunction
endclass

module tb_feistel_index_permutation_core;
    import fip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 3 * DEF_MAX_ROUNDS + 35;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_op = 1'b0;
    logic [31:0]       i_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_mapped_index;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off = 0;
    longint      cycle = 0;
    perm_scoreboard sb;

    feistel_index_permutation_core DUT (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 2_000_000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_mapped(o_mapped_index);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] reg_id, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * reg_id); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_id)
            REG_DOMAIN: sb.domain = val[31:0];
            REG_KEY_LO: sb.key_lo = val;
            REG_KEY_HI: sb.key_hi = val;
            REG_ROUNDS: sb.rounds = val[4:0];
            default: ;
        endcase
    endtask

    // called at a rising edge; valid stays high after the transfer for back-to-back items
    task automatic send_index(logic op, logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1; i_op <= op; i_index <= x;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_index(op, x);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_index(logic [31:0] n);
        case ($urandom_range(3))
            0: return $urandom();
            1: return (n == 0) ? $urandom() : $urandom() % n;
            2: return (n == 0) ? 32'hffff_ffff : n - 1;
            default: return $urandom_range(15);
        endcase
    endfunction

    task automatic random_phase(int items, int sidle, int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (items) send_index($urandom_range(1), rand_index(sb.domain));
        drain();
    endtask

    initial begin
        logic [31:0] dom_choice[6];
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset settings, field extremes, both directions
        send_index(1'b0, 32'd0);
        send_index(1'b1, 32'd0);
        send_index(1'b0, 32'hffff_ffff);
        send_index(1'b1, 32'hffff_ffff);
        send_index(1'b0, 32'd65535);
        drain();
        write_reg(REG_KEY_LO, 64'h0123_4567_89ab_cdef);
        write_reg(REG_KEY_HI, 64'hfedc_ba98_7654_3210);
        // zero domain means the full 32-bit space
        write_reg(REG_DOMAIN, 64'd0);
        send_index(1'b0, 32'hffff_ffff);
        send_index(1'b1, 32'h1234_5678);
        drain();
        // domain of one maps everything to zero
        write_reg(REG_DOMAIN, 64'd1);
        send_index(1'b0, 32'hdead_beef);
        send_index(1'b1, 32'd0);
        drain();
        // excess rounds saturate; zero rounds pass through
        write_reg(REG_ROUNDS, 64'd31);
        write_reg(REG_DOMAIN, 64'h0000_0000_ffff_ffff);
        send_index(1'b0, 32'hffff_fffe);
        send_index(1'b1, 32'h8000_0000);
        drain();
        write_reg(REG_ROUNDS, 64'd0);
        write_reg(REG_DOMAIN, 64'd1000);
        send_index(1'b0, 32'h0001_0000);  // wide left half
        send_index(1'b1, 32'd999);
        drain();

        dom_choice = '{32'd0, 32'd1, 32'd2, 32'd1000, 32'hffff_ffff, 32'd65536};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_DOMAIN,
                      64'(($urandom_range(2) == 0) ? $urandom() : dom_choice[ph]));
            write_reg(REG_KEY_LO, {$urandom(), $urandom()});
            write_reg(REG_KEY_HI, {$urandom(), $urandom()});
            write_reg(REG_ROUNDS,
                      64'((ph == 0) ? 5'd16 : (ph == 1) ? 5'd1 : 5'($urandom_range(31))));
            case (ph % 4)
                0: random_phase(70, 0, 0);
                1: random_phase(70, 62, 0);
                2: random_phase(70, 0, 62);
                default: random_phase(70, 17, 17);
            endcase
        end

        // stall the receiver long enough to back up the pipeline
        hold_off = 3 * LATENCY;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2 * LATENCY) send_index($urandom_range(1), $urandom());
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
